// ===== rtl/rbsa_pkg.sv =====
package rbsa_pkg;

   localparam int OFFSET_BITS = 16;
   localparam int SIZE_BITS   = OFFSET_BITS + 1;
   localparam int ALIGN_BITS  = 2;

   localparam logic [SIZE_BITS-1:0] POOL_SIZE_RESET = SIZE_BITS'(1) << OFFSET_BITS;
   localparam logic [SIZE_BITS-1:0] CAP_MIN = SIZE_BITS'(1) << ALIGN_BITS;
   localparam logic [SIZE_BITS-1:0] CAP_MAX = SIZE_BITS'(1) << OFFSET_BITS;

   typedef enum logic {
      OP_ALLOCATE = 1'b0,
      OP_RELEASE  = 1'b1
   } operation_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_ROOM   = 2'd1,
      STATUS_TOO_LARGE = 2'd2
   } status_type;

   typedef struct packed {
      operation_type          operation;
      logic [SIZE_BITS-1:0]   request_size;
      logic [OFFSET_BITS-1:0] release_offset;
      logic [SIZE_BITS-1:0]   release_real_size;
      logic                   release_valid;
   } req_word_type;

   typedef struct packed {
      status_type             status;
      logic [OFFSET_BITS-1:0] grant_offset;
      logic [SIZE_BITS-1:0]   grant_real_size;
   } rsp_word_type;

endpackage

// ===== rtl/ring_buffer_space_allocator.sv =====
// channel   | ports                                   | direction | handshake
// ----------+-----------------------------------------+-----------+---------------------------
// request   | start, busy, req_word                   | in        | start && !busy
// response  | rsp_strobe, rsp_word                    | out       | rsp_strobe, one cycle
// csr       | csr_valid, csr_ready, csr_data          | in        | csr_valid && csr_ready
//
// a request word can be taken every cycle while busy is low; its response word goes through
// the input register, then the decision logic into the response register, whose outputs drive
// the response ports
// state updates at the edge that loads the response, so back-to-back requests chain
// busy is high only during synchronous reset, which clears state and pool size to 65536
// csr_ready is always high; the receiver cannot stall, each response lasts one cycle
module ring_buffer_space_allocator import rbsa_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_word_type         req_word,
   output logic                 rsp_strobe,
   output rsp_word_type         rsp_word,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [SIZE_BITS-1:0] csr_data
);

   // pool size register
   logic [SIZE_BITS-1:0] pool_size_ff, pool_size_in;
   logic [SIZE_BITS-1:0] capacity;

   // input register
   logic                 item_valid_ff, item_valid_in;
   req_word_type         item_ff;

   // response register
   logic                 rsp_strobe_ff;
   rsp_word_type         rsp_word_ff;
   rsp_word_type         result;

   assign busy      = reset;
   assign csr_ready = 1'b1;

   assign pool_size_in  = (csr_valid && csr_ready) ? csr_data : pool_size_ff;
   assign item_valid_in = start && !busy;

   // capacity in use is the pool size clamped to the legal range
   always_comb begin
      if (pool_size_ff < CAP_MIN) begin
         capacity = CAP_MIN;
      end else if (pool_size_ff > CAP_MAX) begin
         capacity = CAP_MAX;
      end else begin
         capacity = pool_size_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_size_ff  <= POOL_SIZE_RESET;
         item_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         pool_size_ff  <= pool_size_in;
         item_valid_ff <= item_valid_in;
         rsp_strobe_ff <= item_valid_ff;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (item_valid_in) begin
         item_ff <= req_word;
      end
      if (item_valid_ff) begin
         rsp_word_ff <= result;
      end
   end

   // decision logic and the ring state
   rbsa_alloc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid_ff),
      .item       (item_ff),
      .capacity   (capacity),
      .result     (result)
   );

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   // every accepted word gives one response, through the input and response registers
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("response missing for accepted request");

   // no response unless the input register held a valid request before it
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !$past(reset)) |-> $past(item_valid_ff))
      else $error("response without request");

   // refused requests carry no offset
   a_refused_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.status != STATUS_OK) |-> (rsp_word.grant_offset == '0))
      else $error("refused request has an offset");

   // sizes are aligned unless saturated on a too-large request
   a_size_aligned: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.status != STATUS_TOO_LARGE)
         |-> (rsp_word.grant_real_size[ALIGN_BITS-1:0] == '0))
      else $error("reported size not aligned");

endmodule

// ===== rtl/rbsa_alloc_core.sv =====
module rbsa_alloc_core import rbsa_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  req_word_type         item,
   input  logic [SIZE_BITS-1:0] capacity,
   output rsp_word_type         result
);

   logic [SIZE_BITS-1:0] used_start_ff, used_start_in;
   logic [SIZE_BITS-1:0] used_end_ff, used_end_in;
   logic                 pool_full_ff, pool_full_in;

   logic [SIZE_BITS:0]   rel_sum;
   logic [SIZE_BITS-1:0] rel_start;
   logic [SIZE_BITS:0]   round_sum;
   logic [SIZE_BITS:0]   real_size;
   logic [SIZE_BITS-1:0] sat_size;
   logic [SIZE_BITS:0]   total;
   logic [SIZE_BITS:0]   remaining;
   logic [SIZE_BITS+1:0] end_sum;
   logic                 tail_fits;
   logic                 wrap_ok;

   // release: start moves past the freed region, clamped to capacity
   assign rel_sum   = {2'b00, item.release_offset} + {1'b0, item.release_real_size};
   assign rel_start = (rel_sum > {1'b0, capacity}) ? capacity : rel_sum[SIZE_BITS-1:0];

   // round up to the alignment
   assign round_sum = {1'b0, item.request_size} + (SIZE_BITS+1)'((1 << ALIGN_BITS) - 1);
   assign real_size = {round_sum[SIZE_BITS:ALIGN_BITS], ALIGN_BITS'(0)};
   assign sat_size  = real_size[SIZE_BITS] ? '1 : real_size[SIZE_BITS-1:0];

   // free space
   assign total = {1'b0, capacity} + {1'b0, used_start_ff};
   always_comb begin
      if (used_start_ff > used_end_ff || pool_full_ff) begin
         remaining = (used_start_ff > used_end_ff)
                   ? {1'b0, used_start_ff - used_end_ff} : '0;
      end else begin
         remaining = (total > {1'b0, used_end_ff}) ? total - {1'b0, used_end_ff} : '0;
      end
   end

   assign end_sum   = {2'b00, used_end_ff} + {1'b0, real_size};
   assign tail_fits = end_sum <= {2'b00, capacity};
   assign wrap_ok   = (real_size < {1'b0, used_start_ff}) || (used_start_ff == used_end_ff);

   always_comb begin
      used_start_in          = used_start_ff;
      used_end_in            = used_end_ff;
      pool_full_in           = pool_full_ff;
      result.status          = STATUS_OK;
      result.grant_offset    = '0;
      result.grant_real_size = '0;
      case (item.operation)
         OP_RELEASE: begin
            if (item.release_valid) begin
               used_start_in = rel_start;
               pool_full_in  = 1'b0;
            end
         end
         OP_ALLOCATE: begin
            result.grant_real_size = sat_size;
            if (remaining < real_size) begin
               result.status = (real_size > {1'b0, capacity}) ? STATUS_TOO_LARGE
                                                              : STATUS_NO_ROOM;
            end else if (!tail_fits && !wrap_ok) begin
               result.status = STATUS_NO_ROOM;
            end else begin
               if (tail_fits) begin
                  result.grant_offset = used_end_ff[OFFSET_BITS-1:0];
                  used_end_in         = end_sum[SIZE_BITS-1:0];
               end else begin
                  used_end_in = real_size[SIZE_BITS-1:0];
               end
               pool_full_in = (used_end_in == used_start_ff);
            end
         end
         default: begin
            result.status = STATUS_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_start_ff <= '0;
         used_end_ff   <= '0;
         pool_full_ff  <= 1'b0;
      end else if (item_valid) begin
         used_start_ff <= used_start_in;
         used_end_ff   <= used_end_in;
         pool_full_ff  <= pool_full_in;
      end
   end

endmodule
